@@ rtl/ssba_pkg.sv @@
// Package with constants, codes and helper functions for the sonar sector bump avoider.
`timescale 1ns / 1ps

package ssba_pkg;

   localparam logic [15:0] MAX_RANGE = 16'd5000;

   localparam logic [15:0] BUMP_DISTANCE_RESET = 16'd300;
   localparam logic [15:0] NEAR_DISTANCE_RESET = 16'd500;
   localparam logic [7:0]  ROTATION_STEP_RESET = 8'd30;

   localparam logic signed [8:0] FRONT_LIMIT_POS = 9'sd30;
   localparam logic signed [8:0] FRONT_LIMIT_NEG = -9'sd30;
   localparam logic signed [8:0] BACK_LIMIT_POS  = 9'sd150;
   localparam logic signed [8:0] BACK_LIMIT_NEG  = -9'sd150;

   // Reciprocals: 52429 * 5 = 2^18 + 1 and 52429 * 10 = 2^19 + 2.
   localparam logic [15:0] RECIP_FIVE = 16'd52429;

   typedef enum logic [1:0] {
      CSR_BUMP_DISTANCE = 2'd0,
      CSR_NEAR_DISTANCE = 2'd1,
      CSR_ROTATION_STEP = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_BACK_OFF  = 2'd0,
      ACT_FORWARD   = 2'd1,
      ACT_TURN_LEFT = 2'd2,
      ACT_TURN_RIGHT = 2'd3
   } action_kind_type;

   // Truncating division of a 16-bit value by five.
   function automatic logic [13:0] div_by_five(input logic [15:0] value);
      logic [31:0] product;
      product = {16'b0, value} * {16'b0, RECIP_FIVE};
      return product[31:18];
   endfunction

   // Truncating value * 7 / 10 for the turn step.
   function automatic logic [13:0] turn_step(input logic [13:0] fstep);
      logic [16:0] times_seven;
      logic [32:0] product;
      times_seven = {fstep, 3'b000} - {3'b000, fstep};
      product = {16'b0, times_seven} * {17'b0, RECIP_FIVE};
      return product[32:19];
   endfunction

endpackage

@@ rtl/sonar_sector_bump_avoider.sv @@
// Top level of the sonar sector bump avoider: sector minima, sweep evaluation and command output.
// A sweep end that yields commands registers them in the pending command set, which loads them
// into the single output register. Readings are taken one per cycle while no command is pending;
// such a sweep end holds req off while the set drains, one beat per cycle while rsp_tready is high.
// Reset is synchronous and active high: registers return to 300, 500 and 30, the minima to
// the maximum range, the mode to normal, and no command is pending or shown.
`timescale 1ns / 1ps

module sonar_sector_bump_avoider (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sensor_angle[8:0], sensor_range[24:9], zero[31:25]
   input  logic        req_tlast,   // end_of_sweep
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // action_kind[1:0], move_distance[16:2],
                                    // heading_change[25:17], mode_after[26], zero[31:27]
   output logic        rsp_tlast,   // final_command
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic signed [8:0] FRONT_LIMIT_POS_S = ssba_pkg::FRONT_LIMIT_POS;
   localparam logic signed [8:0] FRONT_LIMIT_NEG_S = ssba_pkg::FRONT_LIMIT_NEG;
   localparam logic signed [8:0] BACK_LIMIT_POS_S  = ssba_pkg::BACK_LIMIT_POS;
   localparam logic signed [8:0] BACK_LIMIT_NEG_S  = ssba_pkg::BACK_LIMIT_NEG;
   localparam int ACT_BACK_OFF   = int'(ssba_pkg::ACT_BACK_OFF);
   localparam int ACT_FORWARD    = int'(ssba_pkg::ACT_FORWARD);
   localparam int ACT_TURN_LEFT  = int'(ssba_pkg::ACT_TURN_LEFT);
   localparam int ACT_TURN_RIGHT = int'(ssba_pkg::ACT_TURN_RIGHT);

   logic [15:0] bump_ff;
   logic [15:0] near_ff;
   logic [7:0]  rot_ff;

   logic [15:0] min_ff [4];
   logic [15:0] min_in [4];
   logic        mode_ff;
   logic        mode_in;

   logic [3:0]  pend_mask_ff;
   logic [3:0]  pend_mask_in;
   logic [13:0] pend_fstep_ff;
   logic [7:0]  pend_rot_ff;
   logic        pend_mode_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [14:0] rsp_move_ff;
   logic [8:0]  rsp_head_ff;
   logic        rsp_mode_ff;
   logic        rsp_last_ff;

   logic signed [8:0] angle;
   logic [15:0] range;
   logic [3:0]  sector_hit;
   logic [15:0] upd_min [4];
   logic [3:0]  bump_hit;
   logic [3:0]  near_hit;
   logic        req_fire;
   logic        sweep_end;
   logic        load_out;
   logic [1:0]  next_kind;
   logic [3:0]  next_bit;
   logic [13:0] tstep;
   logic [14:0] next_move;
   logic [8:0]  next_head;

   assign angle     = $signed(req_tdata[8:0]);
   assign range     = req_tdata[24:9];
   assign req_tready = (pend_mask_ff == 4'b0000);
   assign req_fire  = req_tvalid && req_tready;
   assign sweep_end = req_fire && req_tlast;
   assign csr_ready = 1'b1;

   always_comb begin
      sector_hit = 4'b0000;
      if (angle >= FRONT_LIMIT_NEG_S && angle <= FRONT_LIMIT_POS_S) begin
         sector_hit[ACT_BACK_OFF] = 1'b1;
      end else if (angle >= BACK_LIMIT_POS_S || angle <= BACK_LIMIT_NEG_S) begin
         sector_hit[ACT_FORWARD] = 1'b1;
      end else if (angle > FRONT_LIMIT_POS_S) begin
         sector_hit[ACT_TURN_LEFT] = 1'b1;
      end else begin
         sector_hit[ACT_TURN_RIGHT] = 1'b1;
      end
   end

   always_comb begin
      for (int s = 0; s < 4; s++) begin
         upd_min[s]  = (sector_hit[s] && range < min_ff[s]) ? range : min_ff[s];
         bump_hit[s] = (upd_min[s] <= bump_ff);
         near_hit[s] = bump_hit[s] && (upd_min[s] < near_ff);
         if (sweep_end) begin
            min_in[s] = ssba_pkg::MAX_RANGE;
         end else if (req_fire) begin
            min_in[s] = upd_min[s];
         end else begin
            min_in[s] = min_ff[s];
         end
      end
   end

   always_comb begin
      mode_in = mode_ff;
      if (sweep_end) begin
         mode_in = (mode_ff && (bump_hit == 4'b0000)) || (near_hit != 4'b0000);
      end
   end

   // Lowest pending sector goes out first: front, back, left, right.
   always_comb begin
      next_kind = ssba_pkg::ACT_TURN_RIGHT;
      if (pend_mask_ff[ACT_BACK_OFF]) begin
         next_kind = ssba_pkg::ACT_BACK_OFF;
      end else if (pend_mask_ff[ACT_FORWARD]) begin
         next_kind = ssba_pkg::ACT_FORWARD;
      end else if (pend_mask_ff[ACT_TURN_LEFT]) begin
         next_kind = ssba_pkg::ACT_TURN_LEFT;
      end
      next_bit = 4'b0001 << next_kind;
   end

   assign tstep = ssba_pkg::turn_step(pend_fstep_ff);

   always_comb begin
      case (next_kind)
         ssba_pkg::ACT_BACK_OFF: begin
            next_move = 15'(-{1'b0, pend_fstep_ff});
            next_head = 9'd0;
         end
         ssba_pkg::ACT_FORWARD: begin
            next_move = {1'b0, pend_fstep_ff};
            next_head = 9'd0;
         end
         ssba_pkg::ACT_TURN_LEFT: begin
            next_move = {1'b0, tstep};
            next_head = 9'(-{1'b0, pend_rot_ff});
         end
         default: begin
            next_move = {1'b0, tstep};
            next_head = {1'b0, pend_rot_ff};
         end
      endcase
   end

   assign load_out = (pend_mask_ff != 4'b0000) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      pend_mask_in = pend_mask_ff;
      if (load_out) begin
         pend_mask_in = pend_mask_ff & ~next_bit;
      end else if (sweep_end && mode_ff) begin
         pend_mask_in = bump_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bump_ff      <= ssba_pkg::BUMP_DISTANCE_RESET;
         near_ff      <= ssba_pkg::NEAR_DISTANCE_RESET;
         rot_ff       <= ssba_pkg::ROTATION_STEP_RESET;
         mode_ff      <= 1'b0;
         pend_mask_ff <= 4'b0000;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < 4; s++) begin
            min_ff[s] <= ssba_pkg::MAX_RANGE;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               ssba_pkg::CSR_BUMP_DISTANCE: bump_ff <= csr_data;
               ssba_pkg::CSR_NEAR_DISTANCE: near_ff <= csr_data;
               ssba_pkg::CSR_ROTATION_STEP: rot_ff  <= csr_data[7:0];
               default: ;
            endcase
         end
         mode_ff      <= mode_in;
         pend_mask_ff <= pend_mask_in;
         for (int s = 0; s < 4; s++) begin
            min_ff[s] <= min_in[s];
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sweep_end) begin
         pend_fstep_ff <= ssba_pkg::div_by_five(bump_ff);
         pend_rot_ff   <= rot_ff;
         pend_mode_ff  <= mode_in;
      end
      if (load_out) begin
         rsp_kind_ff <= next_kind;
         rsp_move_ff <= next_move;
         rsp_head_ff <= next_head;
         rsp_mode_ff <= pend_mode_ff;
         rsp_last_ff <= ((pend_mask_ff & ~next_bit) == 4'b0000);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_mode_ff, rsp_head_ff, rsp_move_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_minima_bounded: assert property (@(posedge clock) disable iff (reset)
      min_ff[0] <= ssba_pkg::MAX_RANGE && min_ff[1] <= ssba_pkg::MAX_RANGE &&
      min_ff[2] <= ssba_pkg::MAX_RANGE && min_ff[3] <= ssba_pkg::MAX_RANGE)
      else $error("sector minimum above maximum range");

   a_normal_sweep_no_commands: assert property (@(posedge clock) disable iff (reset)
      (sweep_end && !mode_ff) |=> (pend_mask_ff == 4'b0000))
      else $error("commands queued for a sweep that ended in normal mode");

   a_more_beats_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (pend_mask_ff != 4'b0000))
      else $error("non-final command shown with nothing left to send");

   a_mode_changes_at_sweep_end: assert property (@(posedge clock) disable iff (reset)
      !sweep_end |=> $stable(mode_ff))
      else $error("mode changed without a sweep end");

endmodule

@@ dv/sonar_sector_bump_avoider_tb.sv @@
// Self-checking testbench for the sonar sector bump avoider.
`timescale 1ns / 1ps

module sonar_sector_bump_avoider_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      ssba_pkg::action_kind_type kind;
      logic [14:0]      move;
      logic [8:0]       heading;
      logic             mode;
      logic             last;
   } avoid_command_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   ssba_pkg::csr_index_type csr_index = ssba_pkg::CSR_BUMP_DISTANCE;
   logic [15:0] csr_data = '0;

   // Shadow of the block's registers and sweep state.
   logic [15:0] cfg_bump = ssba_pkg::BUMP_DISTANCE_RESET;
   logic [15:0] cfg_near = ssba_pkg::NEAR_DISTANCE_RESET;
   logic [7:0]  cfg_rotation = ssba_pkg::ROTATION_STEP_RESET;
   logic [15:0] front_min = ssba_pkg::MAX_RANGE;
   logic [15:0] back_min = ssba_pkg::MAX_RANGE;
   logic [15:0] left_min = ssba_pkg::MAX_RANGE;
   logic [15:0] right_min = ssba_pkg::MAX_RANGE;
   logic        avoid_mode = 1'b0;

   avoid_command_type pending_commands[$];

   int cycle_count = 0;
   int error_count = 0;
   int mismatch_count = 0;
   int readings_sent = 0;
   int sweeps_closed = 0;
   int commands_checked = 0;
   int csr_writes = 0;
   int input_stall_cycles = 0;

   int send_idle_pct = 0;
   int ready_idle_pct = 0;
   int ready_gap_left = 0;
   int long_stall_left = 0;
   bit long_stall_pending = 1'b0;

   sonar_sector_bump_avoider uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_tvalid && !req_tready && !reset) begin
         input_stall_cycles <= input_stall_cycles + 1;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d commands outstanding.", cycle_count,
                  pending_commands.size());
         $display("sonar_sector_bump_avoider_tb: done, errors");
         $finish;
      end
   end

   // Receiver: random short and long gaps, plus one long hold-off on request.
   always @(posedge clock) begin
      if (long_stall_pending) begin
         long_stall_left = 300;
         long_stall_pending = 1'b0;
      end
      if (long_stall_left > 0) begin
         long_stall_left--;
         rsp_tready <= 1'b0;
      end else if (ready_gap_left > 0) begin
         ready_gap_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < ready_idle_pct) begin
         ready_gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      avoid_command_type got;
      avoid_command_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = ssba_pkg::action_kind_type'(rsp_tdata[1:0]);
         got.move = rsp_tdata[16:2];
         got.heading = rsp_tdata[25:17];
         got.mode = rsp_tdata[26];
         got.last = rsp_tlast;
         if (pending_commands.size() == 0) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("Unexpected command: kind %0d move %0d heading %0d mode %0d last %0d",
                        got.kind, $signed(got.move), $signed(got.heading), got.mode, got.last);
            end
         end else begin
            want = pending_commands.pop_front();
            commands_checked++;
            if (got !== want) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Mismatch: expected kind %0d move %0d heading %0d mode %0d last %0d",
                           want.kind, $signed(want.move), $signed(want.heading), want.mode,
                           want.last);
                  $display("          actual kind %0d move %0d heading %0d mode %0d last %0d",
                           got.kind, $signed(got.move), $signed(got.heading), got.mode,
                           got.last);
               end
            end
         end
      end
   end

   function automatic avoid_command_type command_of(ssba_pkg::action_kind_type kind, int move,
                                                    int heading);
      avoid_command_type cmd;
      cmd.kind = kind;
      cmd.move = 15'(move);
      cmd.heading = 9'(heading);
      cmd.mode = 1'b0;
      cmd.last = 1'b0;
      return cmd;
   endfunction

   // Updates the sector minima and, at the end of a sweep, queues the commands it produces.
   task automatic track_reading(input logic signed [8:0] angle, input logic [15:0] range,
                                input logic last);
      int a;
      int fstep;
      int tstep;
      int rot;
      logic [15:0] mins[4];
      avoid_command_type sweep_cmds[$];
      avoid_command_type cmd;
      a = angle;
      if (a >= -30 && a <= 30) begin
         if (front_min > range) front_min = range;
      end else if (a >= 150 || a <= -150) begin
         if (back_min > range) back_min = range;
      end else if (a > 30) begin
         if (left_min > range) left_min = range;
      end else begin
         if (right_min > range) right_min = range;
      end
      if (!last) return;
      sweeps_closed++;
      fstep = int'(cfg_bump) / 5;
      tstep = (fstep * 7) / 10;
      rot = int'(cfg_rotation);
      mins = '{front_min, back_min, left_min, right_min};
      if (avoid_mode) begin
         if (mins[0] <= cfg_bump) begin
            sweep_cmds.push_back(command_of(ssba_pkg::ACT_BACK_OFF, -fstep, 0));
         end
         if (mins[1] <= cfg_bump) begin
            sweep_cmds.push_back(command_of(ssba_pkg::ACT_FORWARD, fstep, 0));
         end
         if (mins[2] <= cfg_bump) begin
            sweep_cmds.push_back(command_of(ssba_pkg::ACT_TURN_LEFT, tstep, -rot));
         end
         if (mins[3] <= cfg_bump) begin
            sweep_cmds.push_back(command_of(ssba_pkg::ACT_TURN_RIGHT, tstep, rot));
         end
         if (sweep_cmds.size() > 0) avoid_mode = 1'b0;
      end
      if (!avoid_mode) begin
         foreach (mins[i]) begin
            if (mins[i] < cfg_near && mins[i] <= cfg_bump) avoid_mode = 1'b1;
         end
      end
      foreach (sweep_cmds[i]) begin
         cmd = sweep_cmds[i];
         cmd.mode = avoid_mode;
         cmd.last = (i == sweep_cmds.size() - 1);
         pending_commands.push_back(cmd);
      end
      front_min = ssba_pkg::MAX_RANGE;
      back_min = ssba_pkg::MAX_RANGE;
      left_min = ssba_pkg::MAX_RANGE;
      right_min = ssba_pkg::MAX_RANGE;
   endtask

   // Offers one reading, with an optional gap first, and returns in the step of its beat.
   task automatic send_reading(input logic signed [8:0] angle, input logic [15:0] range,
                               input logic last);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, range, angle};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      readings_sent++;
      track_reading(angle, range, last);
   endtask

   // Lets all queued commands drain before the next register write.
   task automatic drain_commands();
      req_tvalid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input ssba_pkg::csr_index_type index, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (index)
         ssba_pkg::CSR_BUMP_DISTANCE: cfg_bump = value;
         ssba_pkg::CSR_NEAR_DISTANCE: cfg_near = value;
         ssba_pkg::CSR_ROTATION_STEP: cfg_rotation = value[7:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input int bump, input int near, input int rotation);
      drain_commands();
      write_csr(ssba_pkg::CSR_BUMP_DISTANCE, 16'(bump));
      write_csr(ssba_pkg::CSR_NEAR_DISTANCE, 16'(near));
      write_csr(ssba_pkg::CSR_ROTATION_STEP, 16'(rotation));
   endtask

   function automatic logic signed [8:0] pick_angle();
      int a;
      if ($urandom_range(0, 7) == 0) a = $urandom_range(0, 511);
      else a = int'($urandom_range(0, 360)) - 180;
      return 9'(a);
   endfunction

   function automatic logic [15:0] pick_range();
      int b;
      b = cfg_bump;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom_range(0, b));
         4: return (b < 65535) ? 16'(b + 1) : 16'(b);
         5, 6: return 16'($urandom_range(0, 65535));
         7: return 16'($urandom_range(4990, 5010));
         8: return 16'($urandom_range(0, cfg_near));
         default: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   task automatic run_random_sweeps(input int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, 5);
         for (int i = 0; i < len; i++) begin
            send_reading(pick_angle(), pick_range(), i == len - 1);
            sent++;
         end
      end
   endtask

   task automatic test_sector_edges();
      send_idle_pct = 20;
      ready_idle_pct = 20;
      send_reading(9'sd0, 16'd100, 1'b1);
      send_reading(-9'sd30, 16'd0, 1'b0);
      send_reading(9'sd150, 16'd300, 1'b0);
      send_reading(9'sd31, 16'd10, 1'b0);
      send_reading(-9'sd31, 16'd299, 1'b0);
      send_reading(-9'sd256, 16'hFFFF, 1'b1);
      send_reading(9'sd30, 16'd301, 1'b0);
      send_reading(-9'sd150, 16'd5000, 1'b0);
      send_reading(9'sd149, 16'hFFFF, 1'b0);
      send_reading(-9'sd149, 16'd4999, 1'b0);
      send_reading(9'sd255, 16'd301, 1'b1);
      send_reading(9'sd180, 16'd0, 1'b0);
      send_reading(-9'sd180, 16'd5001, 1'b1);
      send_reading(9'sd90, 16'd200, 1'b1);
      send_reading(-9'sd90, 16'd300, 1'b1);
      send_reading(-9'sd1, 16'd5000, 1'b0);
      send_reading(9'sd1, 16'hFFFE, 1'b1);
      drain_commands();
   endtask

   task automatic test_register_extremes();
      send_idle_pct = 15;
      ready_idle_pct = 15;
      set_registers(0, 0, 0);
      run_random_sweeps(30);
      set_registers(65535, 65535, 255);
      run_random_sweeps(30);
      set_registers(300, 65535, 180);
      run_random_sweeps(30);
      set_registers(65535, 0, 1);
      run_random_sweeps(25);
      set_registers(1000, 100, 45);
      run_random_sweeps(25);
      drain_commands();
      write_csr(ssba_pkg::CSR_UNUSED, 16'($urandom_range(0, 65535)));
      run_random_sweeps(20);
      set_registers(ssba_pkg::BUMP_DISTANCE_RESET, ssba_pkg::NEAR_DISTANCE_RESET,
                    ssba_pkg::ROTATION_STEP_RESET);
   endtask

   task automatic test_output_backpressure();
      int len;
      drain_commands();
      send_idle_pct = 0;
      ready_idle_pct = 0;
      long_stall_pending = 1'b1;
      for (int s = 0; s < 14; s++) begin
         len = $urandom_range(2, 4);
         for (int i = 0; i < len; i++) begin
            send_reading(pick_angle(), 16'($urandom_range(0, cfg_bump)), i == len - 1);
         end
      end
      drain_commands();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         set_registers($urandom_range(0, 2000), $urandom_range(0, 3000), $urandom_range(0, 180));
         send_idle_pct = (phase % 3 == 0) ? 0 : 25;
         ready_idle_pct = (phase % 2 == 0) ? 0 : 30;
         run_random_sweeps(30);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_sector_edges();
      test_register_extremes();
      test_output_backpressure();
      test_random_traffic();
      drain_commands();
      $display("Sent %0d readings in %0d sweeps and checked %0d commands.", readings_sent,
               sweeps_closed, commands_checked);
      $display("Wrote %0d registers; input held off for %0d cycles.", csr_writes,
               input_stall_cycles);
      if (error_count == 0 && pending_commands.size() == 0) begin
         $display("sonar_sector_bump_avoider_tb: done, clean");
      end else begin
         $display("%0d failures, %0d commands never arrived.", error_count,
                  pending_commands.size());
         $display("sonar_sector_bump_avoider_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/ssba_pkg.sv
rtl/sonar_sector_bump_avoider.sv
dv/sonar_sector_bump_avoider_tb.sv
